// ===== rtl/core/bdc_pkg.sv =====
package bdc_pkg;

  // ASCII codes produced by the formatter
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_COMMA = 8'd44;

  // Digits per thousands group
  localparam int unsigned GROUP_DIGITS = 3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture a new value, clear the BCD digits
    logic dabble;     // one shift-and-add-3 conversion step
    logic shift_dig;  // drop the top BCD digit, move the next one up
    logic sel_comma;  // present a comma rather than the top digit
  } bdc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic top_zero;   // the top BCD digit is zero
  } bdc_status_t;

endpackage

// ===== rtl/core/binary_to_decimal_with_commas_unit.sv =====
// Formats an unsigned binary value as decimal ASCII text with a comma between
// every group of three digits, most significant digit first, no leading zeros
// (zero gives a single '0'). Pulse start while busy is low to hand over value_i;
// the unit then runs one shift-and-add-3 step per value bit (min(VALUE_BITS, 32)
// steps), then drops the leading zero digits one at a time, settles on the
// first digit and then emits the output characters in order. Each character
// appears on char_code_o for exactly one cycle with valid_o high, and last_o
// marks the final one; the receiver cannot stall, so it must take every
// character as it comes. busy is high from the cycle after start is taken until
// the last character, so the next item can be taken in the cycle after it.
module binary_to_decimal_with_commas_unit import bdc_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value_i,
  output logic        valid_o,
  output logic [7:0]  char_code_o,
  output logic        last_o
);

  localparam int unsigned EffBits = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  // decimal digits needed for EffBits bits: floor(EffBits * log10(2)) + 1
  localparam int unsigned NumDig  = ((EffBits * 1233) >> 12) + 1;

  bdc_cmd_t    cmd;
  bdc_status_t status;

  bdc_ctrl #(
    .EffBits(EffBits),
    .NumDig (NumDig)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .status_i(status),
    .cmd_o   (cmd),
    .valid_o (valid_o),
    .last_o  (last_o)
  );

  bdc_datapath #(
    .EffBits(EffBits),
    .NumDig (NumDig)
  ) u_datapath (
    .clk_i      (clk_i),
    .value_i    (value_i[EffBits-1:0]),
    .cmd_i      (cmd),
    .status_o   (status),
    .char_code_o(char_code_o)
  );

endmodule

// ===== rtl/core/bdc_datapath.sv =====
module bdc_datapath import bdc_pkg::*; #(
  parameter int unsigned EffBits = 32,
  parameter int unsigned NumDig  = 10
) (
  input  logic             clk_i,
  input  logic [EffBits-1:0] value_i,
  input  bdc_cmd_t         cmd_i,
  output bdc_status_t      status_o,
  output logic [7:0]       char_code_o
);

  localparam int unsigned BcdBits = NumDig * 4;

  logic [EffBits-1:0] bin_q, bin_d;
  logic [BcdBits-1:0] bcd_q, bcd_d;
  logic [BcdBits-1:0] bcd_adj;
  logic [3:0]         top_dig;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NumDig; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  // Next value of the binary and BCD shift registers
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (cmd_i.load) begin
      bin_d = value_i;
      bcd_d = '0;
    end else if (cmd_i.dabble) begin
      bin_d = {bin_q[EffBits-2:0], 1'b0};
      bcd_d = {bcd_adj[BcdBits-2:0], bin_q[EffBits-1]};
    end else if (cmd_i.shift_dig) begin
      bcd_d = {bcd_q[BcdBits-5:0], 4'b0000};
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign top_dig           = bcd_q[BcdBits-1 -: 4];
  assign status_o.top_zero = (top_dig == 4'd0);

  // Character presented on the result port
  assign char_code_o = cmd_i.sel_comma ? ASCII_COMMA : (ASCII_ZERO + {4'b0000, top_dig});

endmodule

// ===== rtl/core/bdc_ctrl.sv =====
module bdc_ctrl import bdc_pkg::*; #(
  parameter int unsigned EffBits = 32,
  parameter int unsigned NumDig  = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  bdc_status_t status_i,
  output bdc_cmd_t    cmd_o,
  output logic        valid_o,
  output logic        last_o
);

  localparam int unsigned CntW    = $clog2(EffBits + 1);
  localparam int unsigned RemW    = $clog2(NumDig + 1);
  localparam logic [1:0]  GrpInit = 2'((NumDig - 1) % GROUP_DIGITS);
  localparam logic [1:0]  GrpTop  = 2'(GROUP_DIGITS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_SKIP  = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_COMMA = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RemW-1:0] rem_q, rem_d;   // digits still to be emitted
  logic [1:0]      grp_q, grp_d;   // (rem - 1) mod 3
  logic [1:0]      grp_dec;

  assign grp_dec = (grp_q == 2'd0) ? GrpTop : (grp_q - 2'd1);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    grp_d   = grp_q;
    cmd_o   = '0;
    valid_o = 1'b0;
    last_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = CntW'(EffBits);
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.dabble = 1'b1;
        cnt_d        = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          rem_d   = RemW'(NumDig);
          grp_d   = GrpInit;
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, always keep the last digit
        if (status_i.top_zero && (rem_q > RemW'(1))) begin
          cmd_o.shift_dig = 1'b1;
          rem_d           = rem_q - 1'b1;
          grp_d           = grp_dec;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        valid_o = 1'b1;
        if (rem_q == RemW'(1)) begin
          last_o  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.shift_dig = 1'b1;
          rem_d           = rem_q - 1'b1;
          grp_d           = grp_dec;
          if (grp_q == 2'd0) begin
            state_d = ST_COMMA;
          end
        end
      end
      ST_COMMA: begin
        valid_o         = 1'b1;
        cmd_o.sel_comma = 1'b1;
        state_d         = ST_EMIT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      grp_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      grp_q   <= grp_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  // Checks
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> valid_o) else $error("last without a character");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |=> !busy) else $error("still busy after last character");

  a_start_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == ST_CONV)) else $error("item not taken into conversion");

  a_comma_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMA) |-> (rem_q >= RemW'(GROUP_DIGITS))) else $error("comma misplaced");

  a_comma_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMA) |=> (valid_o && !cmd_o.sel_comma)) else $error("comma not followed by digit");

endmodule
